### rtl/slwg_pkg.sv
// Package: shared types, constants and codes for the waypoint generator.
`timescale 1ns / 1ps
package slwg_pkg;
	localparam int MAX_POINTS = 64;
	localparam logic [30:0] SPACING_FLOOR = 31'd3277;
	localparam logic [30:0] SPACING_RESET = 31'd49152;
	localparam logic [30:0] MIN_DIST_RESET = 31'd13107;
	localparam logic CFG_SPACING = 1'b0;
	localparam logic CFG_MIN_DIST = 1'b1;

	typedef struct packed {
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] waypoint_x;
		logic signed [31:0] waypoint_y;
		logic signed [15:0] heading_sin_half;
		logic signed [15:0] heading_cos_half;
		logic [5:0] point_index;
		logic last_point;
		logic count_clamped;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_SQ, ST_SUM, ST_SQRT, ST_CHECK, ST_DIVN, ST_CNT,
		ST_DIVW, ST_SQW, ST_DIVZ, ST_SQZ, ST_DIVP, ST_DIVY, ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DIFF, OP_SQ, OP_SUM, OP_SQRT_START, OP_DIVN_START,
		OP_COUNT, OP_DIVW_START, OP_SQW_START, OP_DIVZ_START, OP_SQZ_START,
		OP_PNT_START, OP_PNT_Y, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic too_close;
		logic last;
	} status_t;
endpackage

### rtl/slwg_sqrt.sv
// Iterative square root: one result bit a cycle, 66-bit radicand.
`timescale 1ns / 1ps
module slwg_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [65:0] radicand,
	output logic busy,
	output logic [32:0] root
);
	logic [65:0] rad_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0] cnt_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;

	assign rem_sh = {rem_q[33:0], rad_q[65:64]};
	assign trial = {1'b0, root_q, 2'b01};
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy) begin
			if (cnt_q == 6'd0) busy <= 1'b0;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q <= {rad_q[63:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[31:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[31:0], 1'b0};
			end
		end
	end
endmodule

### rtl/slwg_div.sv
// Restoring divider: 64-bit dividend by 34-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module slwg_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] dividend,
	input  logic [33:0] divisor,
	output logic busy,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [34:0] rem_q;
	logic [33:0] dvs_q;
	logic [6:0] cnt_q;
	logic [34:0] rem_sh;

	assign rem_sh = {rem_q[33:0], quo_q[63]};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 7'd63;
		end else if (busy) begin
			if (cnt_q == 7'd0) busy <= 1'b0;
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

### rtl/slwg_datapath.sv
// Datapath: operand registers, shared divider and root unit, output register.
`timescale 1ns / 1ps
module slwg_datapath (
	input  logic clk,
	input  logic arst_n,
	input  slwg_pkg::cmd_t cmd,
	output slwg_pkg::status_t status,
	input  slwg_pkg::in_item_t in_item,
	input  logic [30:0] spacing_q,
	input  logic [30:0] min_dist_q,
	output slwg_pkg::out_item_t out_item
);
	import slwg_pkg::*;

	logic signed [32:0] dx_q, dy_q;
	logic [32:0] ax_q, ay_q;
	logic [65:0] sx_q, sy_q, sum_q;
	logic [32:0] d_q;
	logic [30:0] sp_q;
	logic [6:0] n_q;
	logic clamped_q;
	logic [15:0] w_q, z_q;
	logic [5:0] i_q;
	logic [31:0] qx_q;
	logic signed [31:0] rx_q, ry_q;

	logic div_start, sq_start, div_busy, sq_busy;
	logic [63:0] div_a, div_q;
	logic [33:0] div_b;
	logic [65:0] sq_in;
	logic [32:0] sq_root;
	logic [5:0] den;
	logic [15:0] sat;
	logic [32:0] pnt_sel;
	logic [38:0] pnt_prod;

	assign den = n_q[5:0] - 6'd1;
	assign sat = (sq_root > 33'd32767) ? 16'h7fff : sq_root[15:0];
	// x offset first, then y offset, of the current point
	assign pnt_sel = (cmd.op == OP_PNT_Y) ? ay_q : ax_q;
	assign pnt_prod = {6'd0, pnt_sel} * {33'd0, i_q};

	slwg_div u_div (.clk, .arst_n, .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_q));
	slwg_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .radicand(sq_in),
		.busy(sq_busy), .root(sq_root));

	always_comb begin
		div_start = 1'b0;
		sq_start = 1'b0;
		div_a = '0;
		div_b = {1'b0, d_q};
		sq_in = {34'd0, div_q[31:0]};
		unique case (cmd.op)
			OP_SQRT_START: begin
				sq_start = 1'b1;
				sq_in = sum_q;
			end
			OP_DIVN_START: begin
				div_start = 1'b1;
				div_a = {31'd0, sq_root} + {33'd0, sp_q} - 64'd1;
				div_b = {3'd0, sp_q};
			end
			OP_DIVW_START: begin
				div_start = 1'b1;
				div_a = {1'b0, {1'b0, d_q} + {dx_q[32], dx_q}, 29'd0};
			end
			OP_DIVZ_START: begin
				div_start = 1'b1;
				div_a = {1'b0, {1'b0, d_q} - {dx_q[32], dx_q}, 29'd0};
			end
			OP_SQW_START, OP_SQZ_START: sq_start = 1'b1;
			OP_PNT_START, OP_PNT_Y: begin
				div_start = 1'b1;
				div_a = {24'd0, pnt_prod, 1'b0} + {58'd0, den};
				div_b = {27'd0, den, 1'b0};
			end
			default: ;
		endcase
	end

	assign status.busy = div_busy | sq_busy;
	assign status.too_close = d_q < {2'b0, min_dist_q};
	assign status.last = ({1'b0, i_q} == n_q - 7'd1);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rx_q <= in_item.robot_x;
				ry_q <= in_item.robot_y;
				sp_q <= (spacing_q < SPACING_FLOOR) ? SPACING_FLOOR : spacing_q;
				dx_q <= 33'(in_item.goal_x) - 33'(in_item.robot_x);
				dy_q <= 33'(in_item.goal_y) - 33'(in_item.robot_y);
			end
			OP_DIFF: begin
				ax_q <= dx_q[32] ? 33'(-dx_q) : dx_q;
				ay_q <= dy_q[32] ? 33'(-dy_q) : dy_q;
			end
			OP_SQ: begin
				sx_q <= 66'(ax_q) * 66'(ax_q);
				sy_q <= 66'(ay_q) * 66'(ay_q);
			end
			OP_SUM: sum_q <= sx_q + sy_q;
			OP_SQRT_START: ;
			OP_DIVN_START: d_q <= sq_root;
			OP_COUNT: begin
				clamped_q <= (div_q > 64'(MAX_POINTS - 1));
				if (div_q > 64'(MAX_POINTS - 1)) n_q <= 7'(MAX_POINTS);
				else if (div_q == 64'd0) n_q <= 7'd2;
				else n_q <= 7'(div_q) + 7'd1;
				i_q <= '0;
			end
			OP_SQW_START: ;
			OP_DIVZ_START: w_q <= sat;
			OP_PNT_START: begin
				if (d_q == 33'd0) begin
					z_q <= 16'd0;
					w_q <= 16'h7fff;
				end else z_q <= dy_q[32] ? 16'(-sat) : sat;
			end
			OP_PNT_Y: qx_q <= div_q[31:0];
			OP_EMIT: begin
				out_item.waypoint_x <= dx_q[32] ? rx_q - qx_q : rx_q + qx_q;
				out_item.waypoint_y <= dy_q[32] ? ry_q - div_q[31:0]
					: ry_q + div_q[31:0];
				out_item.heading_sin_half <= z_q;
				out_item.heading_cos_half <= w_q;
				out_item.point_index <= i_q;
				out_item.last_point <= ({1'b0, i_q} == n_q - 7'd1);
				out_item.count_clamped <= clamped_q;
				i_q <= i_q + 6'd1;
			end
			default: ;
		endcase
	end
endmodule

### rtl/slwg_ctrl.sv
// Controller: sequences one goal through the datapath and the output handshake.
`timescale 1ns / 1ps
module slwg_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output slwg_pkg::cmd_t cmd,
	input  slwg_pkg::status_t status
);
	import slwg_pkg::*;

	state_t state_q, state_d;
	logic ov_q, ov_d;

	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && out_stall;
		cmd.op = OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin cmd.op = OP_DIFF; state_d = ST_SQ; end
			ST_SQ: begin cmd.op = OP_SQ; state_d = ST_SUM; end
			ST_SUM: begin cmd.op = OP_SUM; state_d = ST_SQRT; end
			ST_SQRT: begin cmd.op = OP_SQRT_START; state_d = ST_CHECK; end
			ST_CHECK: if (!status.busy) begin
				cmd.op = OP_DIVN_START;
				state_d = ST_DIVN;
			end
			ST_DIVN: if (status.too_close) state_d = ST_IDLE;
				else state_d = ST_CNT;
			ST_CNT: if (!status.busy) begin
				cmd.op = OP_COUNT;
				state_d = ST_DIVW;
			end
			ST_DIVW: begin cmd.op = OP_DIVW_START; state_d = ST_SQW; end
			ST_SQW: if (!status.busy) begin
				cmd.op = OP_SQW_START;
				state_d = ST_DIVZ;
			end
			ST_DIVZ: if (!status.busy) begin
				cmd.op = OP_DIVZ_START;
				state_d = ST_SQZ;
			end
			ST_SQZ: if (!status.busy) begin
				cmd.op = OP_SQZ_START;
				state_d = ST_DIVP;
			end
			// x offset of the point
			ST_DIVP: if (!status.busy) begin
				cmd.op = OP_PNT_START;
				state_d = ST_DIVY;
			end
			// y offset of the point
			ST_DIVY: if (!status.busy) begin
				cmd.op = OP_PNT_Y;
				state_d = ST_DIVY == ST_DIVY ? ST_EMIT : ST_EMIT;
			end
			// load the output register once the previous waypoint has gone
			ST_EMIT: if (!status.busy && !(ov_q && out_stall)) begin
				cmd.op = OP_EMIT;
				ov_d = 1'b1;
				state_d = status.last ? ST_IDLE : ST_DIVP;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### rtl/straight_line_waypoint_generator.sv
// Top level of the straight-line waypoint generator.
// Input channel (in_valid/in_stall/in_data): one goal per transfer, robot and goal
// positions in signed Q16.16. in_stall is low only while the block is idle.
// Output channel (out_valid/out_stall/out_data): the waypoints of a goal, in order,
// point_index from 0, last_point on the goal itself. A single output register
// holds one waypoint; while the receiver stalls it stays put, and the block waits
// before loading the next one.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
// is spacing, 1 is min distance. Write only between goals.
// The root and each division run on one shared divider and one root unit. A goal
// that is too close yields nothing. Otherwise the next input transfer can come only
// once the last waypoint of the goal has been loaded into the output register.
// Receiver stalls hold the block up only when a waypoint is still waiting on the
// output when the next one is ready.
// Reset: registers back to their reset values, idle, no output valid.
`timescale 1ns / 1ps
module straight_line_waypoint_generator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  slwg_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output slwg_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [30:0] cfg_data
);
	import slwg_pkg::*;

	logic [30:0] spacing_q, min_dist_q;
	cmd_t cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
			min_dist_q <= MIN_DIST_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SPACING: spacing_q <= cfg_data;
				CFG_MIN_DIST: min_dist_q <= cfg_data;
			endcase
		end
	end

	slwg_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid,
		.out_stall, .cmd, .status);
	slwg_datapath u_dp (.clk, .arst_n, .cmd, .status, .in_item(in_data),
		.spacing_q, .min_dist_q, .out_item(out_data));
endmodule

### bench/testbench.sv
// Self-checking testbench for the straight-line waypoint generator.
`timescale 1ns / 1ps
module testbench;
	import slwg_pkg::*;

	// The settling wait covers the longest run of a goal that gives no waypoints.
	localparam int SETTLE = 400;

	// Kinds of directed row: checked by the predictor, with the results typed in
	// by hand, or expected to give no waypoints.
	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_COINCIDE, ROW_BACK} row_kind_t;
	typedef struct packed {
		row_kind_t kind;
		in_item_t item;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = CFG_SPACING;
	logic [30:0] cfg_data = '0;

	// Register shadows, used by the predictor.
	logic [30:0] spacing_q = SPACING_RESET;
	logic [30:0] min_dist_q = MIN_DIST_RESET;

	out_item_t waypoints_due[$];
	int errors = 0;
	int idle_mode = 0;
	logic hold_req = 0;
	logic hold_done = 0;
	int hold_left = 0;

	straight_line_waypoint_generator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#250ms;
		$display("testbench: errors");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	task automatic expect_point(input out_item_t o);
		waypoints_due = {waypoints_due, o};
	endtask

	// Bitwise floor square root of a 66-bit value.
	function automatic logic [33:0] root66(input logic [65:0] v);
		logic [33:0] r;
		logic [69:0] rem;
		logic [69:0] trial;
		r = '0;
		rem = '0;
		for (int k = 32; k >= 0; k--) begin
			rem = (rem << 2) | 70'((v >> (2 * k)) & 66'd3);
			trial = ({36'd0, r} << 2) | 70'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				r = (r << 1) | 34'd1;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	// Quaternion component from the half-angle identity, saturated to Q1.15.
	function automatic logic [15:0] half_turn(input logic [63:0] num, input logic [63:0] span);
		logic [33:0] r;
		r = root66({2'b00, (num << 29) / span});
		return (r > 34'd32767) ? 16'd32767 : r[15:0];
	endfunction

	// Works out the waypoint run for one goal and queues it.
	task automatic plan_path(input in_item_t it);
		logic signed [33:0] dx, dy;
		logic [32:0] ax, ay;
		logic [65:0] sum;
		logic [63:0] span, sp, n, den, q;
		logic [15:0] zc, wc;
		logic clamped;
		logic signed [63:0] px, py;
		out_item_t o;
		dx = 34'(it.goal_x) - 34'(it.robot_x);
		dy = 34'(it.goal_y) - 34'(it.robot_y);
		ax = dx < 0 ? 33'(-dx) : 33'(dx);
		ay = dy < 0 ? 33'(-dy) : 33'(dy);
		sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
		span = 64'(root66(sum));
		if (span < 64'(min_dist_q))
			return;
		sp = (spacing_q < SPACING_FLOOR) ? 64'(SPACING_FLOOR) : 64'(spacing_q);
		n = (span + sp - 64'd1) / sp + 64'd1;
		if (n < 64'd2)
			n = 64'd2;
		clamped = 0;
		if (n > 64'(MAX_POINTS)) begin
			n = 64'(MAX_POINTS);
			clamped = 1;
		end
		if (span == 0) begin
			zc = 16'd0;
			wc = 16'd32767;
		end else begin
			zc = half_turn(span - 64'(dx), span);
			wc = half_turn(span + 64'(dx), span);
			if (dy < 0)
				zc = -zc;
		end
		den = n - 64'd1;
		for (int i = 0; i < n; i++) begin
			q = (64'(ax) * 64'(i) * 64'd2 + den) / (64'd2 * den);
			px = dx < 0 ? 64'(it.robot_x) - q : 64'(it.robot_x) + q;
			q = (64'(ay) * 64'(i) * 64'd2 + den) / (64'd2 * den);
			py = dy < 0 ? 64'(it.robot_y) - q : 64'(it.robot_y) + q;
			o.waypoint_x = px[31:0];
			o.waypoint_y = py[31:0];
			o.heading_sin_half = zc;
			o.heading_cos_half = wc;
			o.point_index = i[5:0];
			o.last_point = (64'(i) == n - 64'd1);
			o.count_clamped = clamped;
			expect_point(o);
		end
	endtask

	// One goal transfer; valid stays up for a back-to-back item.
	task automatic send_goal(input in_item_t it);
		@(negedge clk);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic sender_gap();
		int gap;
		gap = 0;
		if (idle_mode == 0 && $urandom_range(99) < 13)
			gap = $urandom_range(1, 6);
		else if (idle_mode == 1 && $urandom_range(99) < 45)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Waits for the block to go quiet before touching its registers.
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (waypoints_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [30:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SPACING)
			spacing_q = val;
		else
			min_dist_q = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic in_item_t make_goal(input logic [31:0] rx, input logic [31:0] ry,
			input logic [31:0] gx, input logic [31:0] gy);
		in_item_t it;
		it.robot_x = rx;
		it.robot_y = ry;
		it.goal_x = gx;
		it.goal_y = gy;
		return it;
	endfunction

	// Mostly goals a few spacings away from a random robot, some anywhere.
	function automatic in_item_t random_goal();
		logic [31:0] rx, ry, reach;
		rx = $urandom;
		ry = $urandom;
		case ($urandom_range(9))
			0, 1: return make_goal(rx, ry, $urandom, $urandom);
			2: return make_goal(rx, ry, rx, ry + $urandom_range(0, 400000) - 200000);
			3: return make_goal(rx, ry, rx - $urandom_range(0, 400000), ry);
			default: begin
				reach = 32'd1 << $urandom_range(10, 20);
				return make_goal(rx, ry, rx + $urandom_range(0, reach) - reach / 2,
					ry + $urandom_range(0, reach) - reach / 2);
			end
		endcase
	endfunction

	// Receiver: random stall per idle mode, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			out_stall <= 1;
			hold_left++;
			if (hold_left >= 600)
				hold_done <= 1;
		end else if (idle_mode == 0)
			out_stall <= ($urandom_range(99) < 45);
		else if (idle_mode == 1)
			out_stall <= ($urandom_range(99) < 13);
		else
			out_stall <= 0;
	end

	// Each waypoint transfer is compared with the oldest one due.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (waypoints_due.size() == 0) begin
				report("unexpected waypoint", 64'(out_data.point_index), 64'd0);
			end else begin
				want = waypoints_due.pop_front();
				if (out_data.waypoint_x !== want.waypoint_x)
					report("waypoint_x", 64'(out_data.waypoint_x),
						64'(want.waypoint_x));
				if (out_data.waypoint_y !== want.waypoint_y)
					report("waypoint_y", 64'(out_data.waypoint_y),
						64'(want.waypoint_y));
				if (out_data.heading_sin_half !== want.heading_sin_half)
					report("heading_sin_half", 64'(out_data.heading_sin_half),
						64'(want.heading_sin_half));
				if (out_data.heading_cos_half !== want.heading_cos_half)
					report("heading_cos_half", 64'(out_data.heading_cos_half),
						64'(want.heading_cos_half));
				if (out_data.point_index !== want.point_index)
					report("point_index", 64'(out_data.point_index),
						64'(want.point_index));
				if (out_data.last_point !== want.last_point)
					report("last_point", 64'(out_data.last_point),
						64'(want.last_point));
				if (out_data.count_clamped !== want.count_clamped)
					report("count_clamped", 64'(out_data.count_clamped),
						64'(want.count_clamped));
			end
		end
	end

	initial begin
		row_t rows[$];
		out_item_t o;
		in_item_t it;
		int n_items;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: reset settings first, then zero minimum distance.
		rows = {rows, row_t'{ROW_NONE, make_goal(32'h0001_0000, 32'h0002_0000,
			32'h0001_0000, 32'h0002_0000)}};
		rows = {rows, row_t'{ROW_NONE, make_goal(0, 0, 32'd13106, 0)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(0, 0, 32'd13107, 0)}};
		rows = {rows, row_t'{ROW_BACK, make_goal(32'h0005_0000, 32'hFFFD_0000,
			32'h0004_0000, 32'hFFFD_0000)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(32'h7FFF_FFFF, 0, 32'h8000_0000, 0)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(0, 32'h8000_0000, 0, 32'h7FFF_FFFF)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(0, 0, 32'h0003_0000, 32'hFFFC_0000)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(0, 0, 32'hFFFD_0000, 32'h0004_0000)}};
		rows = {rows, row_t'{ROW_PREDICT, make_goal(0, 0, 32'h0001_0000, 32'h0001_0000)}};
		foreach (rows[r]) begin
			it = rows[r].item;
			send_goal(it);
			case (rows[r].kind)
				ROW_NONE: ;
				ROW_BACK: begin
					// One metre straight back at 0.75 m spacing: three points.
					for (int i = 0; i < 3; i++) begin
						o.waypoint_x = it.robot_x - 32'sd32768 * i;
						o.waypoint_y = it.robot_y;
						o.heading_sin_half = 16'sd32767;
						o.heading_cos_half = 16'sd0;
						o.point_index = i[5:0];
						o.last_point = (i == 2);
						o.count_clamped = 0;
						expect_point(o);
					end
				end
				default: plan_path(it);
			endcase
		end
		drain();

		// Coinciding points with no minimum distance, and spacing below the floor.
		write_reg(CFG_MIN_DIST, 31'd0);
		write_reg(CFG_SPACING, 31'd0);
		it = make_goal(32'hDEAD_BEEF, 32'h1234_5678, 32'hDEAD_BEEF, 32'h1234_5678);
		send_goal(it);
		for (int i = 0; i < 2; i++) begin
			o.waypoint_x = it.robot_x;
			o.waypoint_y = it.robot_y;
			o.heading_sin_half = 16'sd0;
			o.heading_cos_half = 16'sd32767;
			o.point_index = i[5:0];
			o.last_point = (i == 1);
			o.count_clamped = 0;
			expect_point(o);
		end
		send_goal(make_goal(0, 0, 32'h0003_0000, 0));
		plan_path(make_goal(0, 0, 32'h0003_0000, 0));
		drain();

		// Widest settings: nearly every goal too close, the largest spacing.
		write_reg(CFG_SPACING, 31'h7FFF_FFFF);
		write_reg(CFG_MIN_DIST, 31'h7FFF_FFFF);
		for (int k = 0; k < 10; k++) begin
			it = random_goal();
			send_goal(it);
			plan_path(it);
		end
		send_goal(make_goal(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		plan_path(make_goal(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		drain();

		// Random phases, each with its own settings and idle pattern.
		for (int ph = 0; ph < 3; ph++) begin
			idle_mode = ph;
			case (ph)
				0: begin
					write_reg(CFG_SPACING, 31'd3277);
					write_reg(CFG_MIN_DIST, 31'd0);
				end
				1: begin
					write_reg(CFG_SPACING, 31'($urandom_range(3000, 300000)));
					write_reg(CFG_MIN_DIST, 31'($urandom_range(0, 20000)));
				end
				default: begin
					write_reg(CFG_SPACING, 31'd49152);
					write_reg(CFG_MIN_DIST, 31'd13107);
				end
			endcase
			n_items = 165;
			for (int k = 0; k < n_items; k++) begin
				// Receiver holds off while goals keep coming: the block backs up.
				if (ph == 0 && k == 20)
					hold_req = 1;
				// Sender waits for the whole backlog once.
				if (ph == 1 && k == 80) begin
					@(negedge clk);
					in_valid <= 0;
					while (waypoints_due.size() != 0) @(posedge clk);
				end
				it = random_goal();
				send_goal(it);
				plan_path(it);
				sender_gap();
			end
			drain();
		end

		if (errors == 0 && waypoints_due.size() == 0) begin
			$display("testbench: clean");
		end else begin
			if (waypoints_due.size() != 0)
				report("waypoints never seen", 64'(waypoints_due.size()), 64'd0);
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
